/* hw/rtl/dsc_pkg.sv */
package dsc_pkg;

    // Input action codes
    typedef enum logic [2:0] {
        ACT_WINDOW = 3'd0,
        ACT_STREAM = 3'd1,
        ACT_CMD    = 3'd2,
        ACT_PARAM  = 3'd3,
        ACT_PLOT   = 3'd4
    } action_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE     = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_HEIGHT   = 3'd2,
        CFG_COL_CODE = 3'd3,
        CFG_ROW_CODE = 3'd4,
        CFG_MW_CODE  = 3'd5
    } cfg_idx_t;

    // Panel mode: word-padded bus; bit 1 selects 24-bit pixels
    localparam logic [1:0] MODE_WORD_PAD = 2'd1;
    localparam int         MODE_PIX24_BIT = 1;

    localparam int CFG_DATA_W = 10;

    // Job kinds handed from front to back
    typedef enum logic [1:0] {
        JOB_WINDOW = 2'd0,
        JOB_PLOT   = 2'd1,
        JOB_CTL    = 2'd2,
        JOB_PIXEL  = 2'd3
    } job_kind_t;

    // Byte slots of a job; control slots are those up to EL_CODE
    typedef enum logic [3:0] {
        EL_COL_CMD = 4'd0,
        EL_X_HI    = 4'd1,
        EL_X_LO    = 4'd2,
        EL_XE_HI   = 4'd3,
        EL_XE_LO   = 4'd4,
        EL_ROW_CMD = 4'd5,
        EL_Y_HI    = 4'd6,
        EL_Y_LO    = 4'd7,
        EL_YE_HI   = 4'd8,
        EL_YE_LO   = 4'd9,
        EL_MW_CMD  = 4'd10,
        EL_MW_AGN  = 4'd11,
        EL_CODE    = 4'd12,
        EL_PIX0    = 4'd13,
        EL_PIX1    = 4'd14,
        EL_PIX2    = 4'd15
    } elem_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] width;
        logic [9:0] height;
        logic [7:0] col_code;
        logic [7:0] row_code;
        logic [7:0] mw_code;
    } cfg_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] xe;
        logic [15:0] ye;
        logic [15:0] color;
        logic [7:0]  code;
        logic        code_data;
        logic        burst;
    } job_t;

endpackage

/* hw/rtl/dsc_front.sv */
module dsc_front (
    input  dsc_pkg::cfg_t  cfg,
    input  logic           in_fire,
    input  logic [2:0]     action,
    input  logic [15:0]    pos_x,
    input  logic [15:0]    pos_y,
    input  logic [15:0]    span_w,
    input  logic [15:0]    span_h,
    input  logic [15:0]    pixel_color,
    input  logic [7:0]     code_byte,
    input  logic           burst_end,
    output logic           push,
    output dsc_pkg::job_t  job
);
    import dsc_pkg::*;

    logic        keep;
    logic [15:0] w_eff;
    logic [15:0] h_eff;

    // Classify the beat and drop what makes no bytes
    always_comb
    begin
        keep          = 1'b0;
        w_eff         = span_w;
        h_eff         = span_h;
        job.kind      = JOB_WINDOW;
        job.code_data = 1'b0;
        case (action_t'(action))
            ACT_WINDOW:
            begin
                keep     = 1'b1;
                job.kind = JOB_WINDOW;
            end
            ACT_STREAM:
            begin
                keep     = 1'b1;
                job.kind = JOB_PIXEL;
            end
            ACT_CMD:
            begin
                keep     = 1'b1;
                job.kind = JOB_CTL;
            end
            ACT_PARAM:
            begin
                keep          = 1'b1;
                job.kind      = JOB_CTL;
                job.code_data = 1'b1;
            end
            ACT_PLOT:
            begin
                keep     = (pos_x < {6'd0, cfg.height}) && (pos_y < {6'd0, cfg.width});
                job.kind = JOB_PLOT;
                w_eff    = 16'd1;
                h_eff    = 16'd1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase

        // Work out window end addresses, wrapping at 16 bits
        job.x     = pos_x;
        job.y     = pos_y;
        job.xe    = pos_x + w_eff - 16'd1;
        job.ye    = pos_y + h_eff - 16'd1;
        job.color = pixel_color;
        job.code  = code_byte;
        job.burst = burst_end;
    end

    assign push = in_fire && keep;

endmodule

/* hw/rtl/dsc_queue.sv */
module dsc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dsc_pkg::job_t  push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output dsc_pkg::job_t  head_job
);
    import dsc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/dsc_back.sv */
module dsc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  dsc_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  dsc_pkg::job_t  head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     spi_byte,
    output logic           is_data,
    output logic           run_last,
    output logic           burst_done
);
    import dsc_pkg::*;

    elem_t      elem_reg;
    elem_t      elem_next;
    logic       pad_done_reg;
    logic       pad_done_next;
    logic       fresh_reg;
    logic       fresh_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic       data_reg;
    logic       last_reg;
    logic       burst_reg;

    elem_t      cur;
    elem_t      step;
    elem_t      start;
    logic       cur_pad_done;
    logic       advance;
    logic       pix24;
    logic       is_ctl;
    logic       send_pad;
    logic       last_el;
    logic [7:0] el_byte;
    logic       el_data;
    logic [7:0] gen_byte;
    logic       gen_last;

    assign pix24   = cfg.mode[MODE_PIX24_BIT];
    assign advance = head_valid && (!out_valid_reg || !out_stall);

    // Pick the first slot of a new job
    always_comb
    begin
        case (head_job.kind)
            JOB_WINDOW: start = EL_COL_CMD;
            JOB_PLOT:   start = EL_COL_CMD;
            JOB_CTL:    start = EL_CODE;
            JOB_PIXEL:  start = EL_PIX0;
            default:    start = EL_COL_CMD;
        endcase
    end

    assign cur          = fresh_reg ? start : elem_reg;
    assign cur_pad_done = fresh_reg ? 1'b0 : pad_done_reg;
    assign is_ctl       = (cur <= EL_CODE);
    assign send_pad     = (cfg.mode == MODE_WORD_PAD) && is_ctl && !cur_pad_done;

    // Form the byte and flag of the current slot
    always_comb
    begin
        el_data = 1'b1;
        case (cur)
            EL_COL_CMD:
            begin
                el_byte = cfg.col_code;
                el_data = 1'b0;
            end
            EL_X_HI:  el_byte = head_job.x[15:8];
            EL_X_LO:  el_byte = head_job.x[7:0];
            EL_XE_HI: el_byte = head_job.xe[15:8];
            EL_XE_LO: el_byte = head_job.xe[7:0];
            EL_ROW_CMD:
            begin
                el_byte = cfg.row_code;
                el_data = 1'b0;
            end
            EL_Y_HI:  el_byte = head_job.y[15:8];
            EL_Y_LO:  el_byte = head_job.y[7:0];
            EL_YE_HI: el_byte = head_job.ye[15:8];
            EL_YE_LO: el_byte = head_job.ye[7:0];
            EL_MW_CMD, EL_MW_AGN:
            begin
                el_byte = cfg.mw_code;
                el_data = 1'b0;
            end
            EL_CODE:
            begin
                el_byte = head_job.code;
                el_data = head_job.code_data;
            end
            EL_PIX0:
                el_byte = pix24 ? {head_job.color[15:11], 3'b000} : head_job.color[15:8];
            EL_PIX1:
                el_byte = pix24 ? {head_job.color[10:5], 2'b00} : head_job.color[7:0];
            EL_PIX2:  el_byte = {head_job.color[4:0], 3'b000};
            default:  el_byte = 8'h00;
        endcase
    end

    // Decide whether this slot closes the job, and which slot follows
    always_comb
    begin
        last_el = 1'b0;
        step    = elem_t'(cur + 4'd1);
        case (cur)
            EL_MW_CMD:
            begin
                last_el = (head_job.kind == JOB_WINDOW);
                step    = (cfg.mode != 2'd0) ? EL_MW_AGN : EL_PIX0;
            end
            EL_MW_AGN: step = EL_PIX0;
            EL_CODE:   last_el = 1'b1;
            EL_PIX1:   last_el = !pix24;
            EL_PIX2:   last_el = 1'b1;
            default:   last_el = 1'b0;
        endcase
    end

    assign gen_byte = send_pad ? 8'h00 : el_byte;
    assign gen_last = !send_pad && last_el;
    assign pop      = advance && gen_last;

    // Sequence slots of the head job
    always_comb
    begin
        elem_next      = elem_reg;
        pad_done_next  = pad_done_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (send_pad)
            begin
                elem_next     = cur;
                pad_done_next = 1'b1;
                fresh_next    = 1'b0;
            end
            else if (last_el)
            begin
                fresh_next = 1'b1;
            end
            else
            begin
                elem_next     = step;
                pad_done_next = 1'b0;
                fresh_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg      <= EL_COL_CMD;
            pad_done_reg  <= 1'b0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            elem_reg      <= elem_next;
            pad_done_reg  <= pad_done_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg  <= gen_byte;
            data_reg  <= el_data;
            last_reg  <= gen_last;
            burst_reg <= gen_last && head_job.burst;
        end
    end

    assign out_valid  = out_valid_reg;
    assign spi_byte   = byte_reg;
    assign is_data    = data_reg;
    assign run_last   = last_reg;
    assign burst_done = burst_reg;

endmodule

/* hw/rtl/display_spi_command_serializer_top.sv */
// An item's beat is written into the job queue, and its first byte is registered as the
// output beat once the item reaches the queue head. The back sequencer emits one byte per
// cycle while out_stall is low; an item makes 2 or 3 bytes for a pixel, up to 26 for a
// padded plot. Items that make no bytes are dropped; the job queue holds QUEUE_DEPTH items.
// Reset (rst_n low, asynchronous) empties the queue and output and loads default registers.
module display_spi_command_serializer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] span_w,
    input  logic [15:0] span_h,
    input  logic [15:0] pixel_color,
    input  logic [7:0]  code_byte,
    input  logic        burst_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  spi_byte,
    output logic        is_data,
    output logic        run_last,
    output logic        burst_done
);
    import dsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic full;
    logic head_valid;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MODE:     cfg_next.mode     = cfg_data[1:0];
                CFG_WIDTH:    cfg_next.width    = cfg_data[9:0];
                CFG_HEIGHT:   cfg_next.height   = cfg_data[9:0];
                CFG_COL_CODE: cfg_next.col_code = cfg_data[7:0];
                CFG_ROW_CODE: cfg_next.row_code = cfg_data[7:0];
                CFG_MW_CODE:  cfg_next.mw_code  = cfg_data[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= 2'd0;
            cfg_reg.width    <= 10'd320;
            cfg_reg.height   <= 10'd240;
            cfg_reg.col_code <= 8'h2A;
            cfg_reg.row_code <= 8'h2B;
            cfg_reg.mw_code  <= 8'h2C;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = full;

    dsc_front u_front (
        .cfg         (cfg_reg),
        .in_fire     (in_valid && !full),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_w      (span_w),
        .span_h      (span_h),
        .pixel_color (pixel_color),
        .code_byte   (code_byte),
        .burst_end   (burst_end),
        .push        (push),
        .job         (front_job)
    );

    dsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (front_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    dsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .spi_byte   (spi_byte),
        .is_data    (is_data),
        .run_last   (run_last),
        .burst_done (burst_done)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import dsc_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_PER_SET = 28;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 16;

    // Action codes the block has no use for
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] color;
        logic [7:0]  code;
        logic        burst;
    } request_t;

    typedef struct packed {
        logic [7:0] value;
        logic       dc;
        logic       last;
        logic       burst;
    } spi_beat_t;

    // Byte stream predictor with its own copy of the panel registers
    class spi_stream_model;
        logic [1:0] mode;
        logic [9:0] width;
        logic [9:0] height;
        logic [7:0] col_code;
        logic [7:0] row_code;
        logic [7:0] mw_code;
        spi_beat_t  pending[$];
        int         errors;

        function new();
            mode     = 2'd0;
            width    = 10'd320;
            height   = 10'd240;
            col_code = 8'h2A;
            row_code = 8'h2B;
            mw_code  = 8'h2C;
            errors   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [9:0] value);
            case (idx)
                CFG_MODE:     mode     = value[1:0];
                CFG_WIDTH:    width    = value;
                CFG_HEIGHT:   height   = value;
                CFG_COL_CODE: col_code = value[7:0];
                CFG_ROW_CODE: row_code = value[7:0];
                CFG_MW_CODE:  mw_code  = value[7:0];
                default: ;
            endcase
        endfunction

        function void put_byte(logic [7:0] value, logic dc);
            spi_beat_t b;
            b.value = value;
            b.dc    = dc;
            b.last  = 1'b0;
            b.burst = 1'b0;
            pending.push_back(b);
        endfunction

        // Word-padded bus: lead each control byte with a zero of the same flag
        function void put_ctl(logic [7:0] value, logic dc);
            if (mode == MODE_WORD_PAD)
                put_byte(8'h00, dc);
            put_byte(value, dc);
        endfunction

        function void put_pixel(logic [15:0] c);
            if (mode[MODE_PIX24_BIT])
            begin
                put_byte({c[15:11], 3'b000}, 1'b1);
                put_byte({c[10:5], 2'b00}, 1'b1);
                put_byte({c[4:0], 3'b000}, 1'b1);
            end
            else
            begin
                put_byte(c[15:8], 1'b1);
                put_byte(c[7:0], 1'b1);
            end
        endfunction

        function void put_range(logic [7:0] code, logic [15:0] start, logic [15:0] span);
            logic [15:0] stop;
            stop = start + span - 16'd1;
            put_ctl(code, 1'b0);
            put_ctl(start[15:8], 1'b1);
            put_ctl(start[7:0], 1'b1);
            put_ctl(stop[15:8], 1'b1);
            put_ctl(stop[7:0], 1'b1);
        endfunction

        function void put_window(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                 logic [15:0] h);
            put_range(col_code, x, w);
            put_range(row_code, y, h);
            put_ctl(mw_code, 1'b0);
        endfunction

        function void note_request(request_t r);
            int        first;
            spi_beat_t tail;
            first = pending.size();
            case (r.act)
                ACT_WINDOW: put_window(r.x, r.y, r.w, r.h);
                ACT_STREAM: put_pixel(r.color);
                ACT_CMD:    put_ctl(r.code, 1'b0);
                ACT_PARAM:  put_ctl(r.code, 1'b1);
                ACT_PLOT:
                begin
                    // Off panel: x against height, y against width
                    if (r.x < {6'd0, height} && r.y < {6'd0, width})
                    begin
                        put_window(r.x, r.y, 16'd1, 16'd1);
                        if (mode != 2'd0)
                            put_ctl(mw_code, 1'b0);
                        put_pixel(r.color);
                    end
                end
                default: ;
            endcase
            // Mark the last byte of the request and echo its burst flag there
            if (pending.size() > first)
            begin
                tail       = pending.pop_back();
                tail.last  = 1'b1;
                tail.burst = r.burst;
                pending.push_back(tail);
            end
        endfunction

        function void check_byte(spi_beat_t got);
            spi_beat_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected byte %h dc %b last %b burst %b",
                         $time, got.value, got.dc, got.last, got.burst);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value)
            begin
                $display("%0t: spi_byte expected %h actual %h", $time, want.value, got.value);
                errors++;
            end
            if (got.dc !== want.dc)
            begin
                $display("%0t: is_data expected %b actual %b", $time, want.dc, got.dc);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: run_last expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
            if (got.burst !== want.burst)
            begin
                $display("%0t: burst_done expected %b actual %b", $time, want.burst,
                         got.burst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] span_w;
    logic [15:0] span_h;
    logic [15:0] pixel_color;
    logic [7:0]  code_byte;
    logic        burst_end;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  spi_byte;
    logic        is_data;
    logic        run_last;
    logic        burst_done;

    spi_stream_model model;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_trigger;
    int hold_seen;
    int hold_left;
    int cycle_count;

    display_spi_command_serializer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_w      (span_w),
        .span_h      (span_h),
        .pixel_color (pixel_color),
        .code_byte   (code_byte),
        .burst_end   (burst_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .spi_byte    (spi_byte),
        .is_data     (is_data),
        .run_last    (run_last),
        .burst_done  (burst_done)
    );

    always #5 clk = ~clk;

    // Receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check every byte beat that leaves the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            model.check_byte({spi_byte, is_data, run_last, burst_done});
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] act, logic [15:0] x, logic [15:0] y,
                                logic [15:0] w, logic [15:0] h, logic [15:0] color,
                                logic [7:0] code, logic burst);
        request_t r;
        r.act   = act;
        r.x     = x;
        r.y     = y;
        r.w     = w;
        r.h     = h;
        r.color = color;
        r.code  = code;
        r.burst = burst;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pos_x       <= x;
        pos_y       <= y;
        span_w      <= w;
        span_h      <= h;
        pixel_color <= color;
        code_byte   <= code;
        burst_end   <= burst;
        // Hold the beat until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        model.note_request(r);
    endtask

    // Drop valid and wait for every expected byte, then let the pipe empty
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [9:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        model.write_reg(idx, value);
    endtask

    task automatic configure(logic [1:0] mode, logic [9:0] width, logic [9:0] height,
                             logic [7:0] col, logic [7:0] row, logic [7:0] mw);
        write_reg(CFG_MODE, {8'd0, mode});
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
        write_reg(CFG_COL_CODE, {2'd0, col});
        write_reg(CFG_ROW_CODE, {2'd0, row});
        write_reg(CFG_MW_CODE, {2'd0, mw});
    endtask

    function automatic logic [15:0] pick_span();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 64));
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random request; plots mostly land on the panel or just past its edge
    task automatic random_request(output bit counted);
        int          pick;
        logic [2:0]  act;
        logic [15:0] x;
        logic [15:0] y;
        pick = $urandom_range(99);
        x    = 16'($urandom);
        y    = 16'($urandom);
        if (pick < 40)
            act = ACT_STREAM;
        else if (pick < 55)
            act = ACT_WINDOW;
        else if (pick < 75)
        begin
            act = ACT_PLOT;
            if ($urandom_range(3) != 0)
            begin
                x = 16'($urandom_range(0, int'(model.height) + 1));
                y = 16'($urandom_range(0, int'(model.width) + 1));
            end
        end
        else if (pick < 85)
            act = ACT_CMD;
        else if (pick < 96)
            act = ACT_PARAM;
        else
            act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        counted = (act <= ACT_PLOT);
        send_request(act, x, y, pick_span(), pick_span(), 16'($urandom),
                     8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        bit counted;
        int sent;
        model          = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_MODE;
        cfg_data       = 10'd0;
        in_valid       = 1'b0;
        action         = ACT_WINDOW;
        pos_x          = 16'd0;
        pos_y          = 16'd0;
        span_w         = 16'd0;
        span_h         = 16'd0;
        pixel_color    = 16'd0;
        code_byte      = 8'd0;
        burst_end      = 1'b0;
        out_stall      = 1'b0;
        hold_trigger   = 0;
        hold_seen      = 0;
        hold_left      = 0;
        cycle_count    = 0;
        send_idle_pct  = 25;
        recv_stall_pct = 72;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every action, edge of panel, spare codes
        send_request(ACT_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_request(ACT_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_request(ACT_WINDOW, 16'd10, 16'd20, 16'd100, 16'd50, 16'h0000, 8'h00, 1'b0);
        send_request(ACT_STREAM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_request(ACT_STREAM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_request(ACT_STREAM, 16'd0, 16'd0, 16'd0, 16'd0, 16'hF800, 8'h00, 1'b0);
        send_request(ACT_STREAM, 16'd0, 16'd0, 16'd0, 16'd0, 16'h07E0, 8'h00, 1'b0);
        send_request(ACT_STREAM, 16'd0, 16'd0, 16'd0, 16'd0, 16'h001F, 8'h00, 1'b1);
        send_request(ACT_CMD, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b0);
        send_request(ACT_CMD, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b1);
        send_request(ACT_PARAM, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b1);
        send_request(ACT_PARAM, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b0);
        send_request(ACT_PLOT, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 8'h00, 1'b0);
        send_request(ACT_PLOT, 16'd239, 16'd319, 16'd0, 16'd0, 16'h1234, 8'h00, 1'b1);
        send_request(ACT_PLOT, 16'd240, 16'd0, 16'd0, 16'd0, 16'hABCD, 8'h00, 1'b1);
        send_request(ACT_PLOT, 16'd0, 16'd320, 16'd0, 16'd0, 16'hABCD, 8'h00, 1'b0);
        send_request(ACT_PLOT, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'h5555, 8'h00, 1'b1);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            send_request(3'(a), 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 8'h01, 1'b1);
        send_request(ACT_STREAM, 16'd0, 16'd0, 16'd0, 16'd0, 16'hA5A5, 8'h00, 1'b1);

        // Register settings in turn, idling pattern shifting across them
        for (int set = 0; set < 7; set++)
        begin
            if (set > 0)
            begin
                drain();
                case (set)
                    1: configure(2'd1, 10'd1023, 10'd1023, 8'hFF, 8'h00, 8'h80);
                    2: configure(2'd2, 10'd1, 10'd1, 8'h00, 8'hFF, 8'h01);
                    3: configure(2'd3, 10'd0, 10'd17, 8'h55, 8'hAA, 8'hFF);
                    4: configure(2'($urandom), 10'($urandom_range(1, 64)),
                                 10'($urandom_range(1, 64)), 8'($urandom), 8'($urandom),
                                 8'($urandom));
                    5: configure(2'($urandom), 10'($urandom), 10'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                    default: configure(2'd1, 10'($urandom_range(1, 40)), 10'd0,
                                       8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            if (set < 2)
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 72;
            end
            else if (set < 4)
            begin
                send_idle_pct  = 72;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // Hold the receiver off while requests keep coming to fill the queue
            if (set == 4)
                hold_trigger++;
            sent = 0;
            while (sent < RANDOM_PER_SET)
            begin
                random_request(counted);
                if (counted)
                    sent++;
            end
        end

        drain();
        if (model.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
